### hdl/assert_macros.svh
// Assertion macros for the raycaster checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define GCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gcr check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define GCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gcr check failed");

`endif

### hdl/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared constants, types and tables of the grid column raycaster.
// ----------------------------------------------------------------------------
`default_nettype none

package gcr_pkg;

  localparam int SCREEN_WIDTH  = 120;
  localparam int SCREEN_HEIGHT = 35;
  localparam int MAP_SIZE      = 16;
  localparam int FOV_UNITS     = 512;
  localparam int MAX_DEPTH     = 16;

  localparam int STEP_Q12  = 410;
  localparam int DEPTH_Q12 = MAX_DEPTH * 4096;
  localparam int EDGE_SIN2 = 26843;

  // widths
  localparam int ROW_W   = 6;
  localparam int E_W     = 16;
  localparam int D_W     = 17;
  localparam int Q_W     = 33;
  localparam int V_W     = 18;
  localparam int MW      = 35;
  localparam int PW      = 2 * MW;
  localparam int DSQ_W   = 34;
  localparam int NUM_W   = 25;
  localparam int DV_W    = NUM_W - 1;
  localparam int DS_W    = D_W + 1;
  localparam int CEIL_W  = 12;
  localparam int ROM_AW  = 11;

  typedef enum logic [2:0] {
    GLYPH_BLANK  = 3'd0,
    GLYPH_FULL   = 3'd1,
    GLYPH_DARK   = 3'd2,
    GLYPH_MEDIUM = 3'd3,
    GLYPH_LIGHT  = 3'd4,
    GLYPH_HASH   = 3'd5,
    GLYPH_X      = 3'd6,
    GLYPH_DOT    = 3'd7
  } glyph_t;

  localparam logic [2:0] CFG_WALL_A = 3'd0;
  localparam logic [2:0] CFG_WALL_D = 3'd3;

  // Column offset table: column*FOV/width, modulo one turn
  typedef logic [11:0] col_tab_t [0:127];

  function automatic col_tab_t build_col_tab();
    col_tab_t t;
    for (int c = 0; c < 128; c++) begin
      t[c] = 12'((c * FOV_UNITS) / SCREEN_WIDTH);
    end
    return t;
  endfunction

  localparam col_tab_t COL_TAB = build_col_tab();

  // Quarter-wave sine magnitude, Q1.14, for k = 0..1024
  typedef logic [E_W-1:0] sin_tab_t [0:1024];

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t        tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned r;
    longint unsigned one;
    one = 64'd1073741824;
    for (int k = 0; k <= 1024; k++) begin
      x  = (longint'(k) * 64'd3373259426) / 2048;
      x2 = (x * x) >> 30;
      t  = one - x2 / 72;
      t  = one - ((x2 * t) >> 30) / 42;
      t  = one - ((x2 * t) >> 30) / 20;
      t  = one - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      r  = (s + 64'd32768) >> 16;
      if (r > 64'd16384) r = 64'd16384;
      tab[k] = E_W'(r);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

`default_nettype wire

### hdl/grid_column_raycaster.sv
// ----------------------------------------------------------------------------
// grid_column_raycaster
// Casts one ray for a screen column over a 16x16 wall map and emits the
// column's glyphs, top row first.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The block then looks
// up the ray direction, marches one 410/4096-unit step per cycle (at most
// 160 steps), tests the hit cell's corners on the shared multiplier after a
// wall hit, finds the ceiling row on a bit-serial divider and emits
// SCREEN_HEIGHT rows on consecutive cycles, each on out_row/out_glyph/
// out_last_row with out_valid high for one cycle. The receiver must take
// every row as it comes. The march length sets most of a column's time.
`default_nettype none

module grid_column_raycaster
  import gcr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [6:0]  in_column,
  input  wire logic [15:0] in_viewer_x,
  input  wire logic [15:0] in_viewer_y,
  input  wire logic [11:0] in_view_angle,
  output logic             out_valid,
  output logic [ROW_W-1:0] out_row,
  output logic [2:0]       out_glyph,
  output logic             out_last_row,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_SIN_X = 11'b000_0000_0010,
    ST_SIN_Y = 11'b000_0000_0100,
    ST_SIN_E = 11'b000_0000_1000,
    ST_STEPC = 11'b000_0001_0000,
    ST_MARCH = 11'b000_0010_0000,
    ST_DIST  = 11'b000_0100_0000,
    ST_TEST  = 11'b000_1000_0000,
    ST_DIVS  = 11'b001_0000_0000,
    ST_DIVW  = 11'b010_0000_0000,
    ST_ROWS  = 11'b100_0000_0000
  } state_t;

  localparam logic signed [10:0]       STEP_S = 11'sd410;
  localparam logic [D_W-1:0]           STEP_D = D_W'(STEP_Q12);
  localparam logic [D_W-1:0]           DEPTH_D = D_W'(DEPTH_Q12);
  localparam logic signed [NUM_W-1:0]  H_S = NUM_W'(SCREEN_HEIGHT);
  localparam logic signed [CEIL_W-1:0] H_C = CEIL_W'(SCREEN_HEIGHT);
  localparam logic [11:0]              HALF_FOV = 12'(FOV_UNITS / 2);

  state_t                   state_r, state_nxt;
  logic [63:0]              wall_r [4];
  logic [15:0]              px_r, px_nxt, py_r, py_nxt;
  logic [11:0]              ang_r, ang_nxt;
  logic signed [E_W-1:0]    ex_r, ex_nxt, ey_r, ey_nxt;
  logic signed [Q_W-1:0]    stepx_r, stepx_nxt, stepy_r, stepy_nxt;
  logic signed [Q_W-1:0]    qx_r, qx_nxt, qy_r, qy_nxt;
  logic [D_W-1:0]           d_r, d_nxt;
  logic [3:0]               cx_r, cx_nxt, cy_r, cy_nxt;
  logic [1:0]               k_r, k_nxt, far_r, far_nxt;
  logic [2:0]               ph_r, ph_nxt;
  logic signed [PW-1:0]     acc_r, acc_nxt, dot_r, dot_nxt;
  logic [DSQ_W-1:0]         dsq_r [4];
  logic [DSQ_W-1:0]         dsq_new;
  logic                     dsq_we;
  logic                     edge_r, edge_nxt;
  glyph_t                   shade_r, shade_nxt;
  logic signed [CEIL_W-1:0] ceil_r, ceil_nxt;
  logic [ROW_W-1:0]         y_r, y_nxt;
  logic                     out_valid_nxt;
  logic [ROW_W-1:0]         out_row_nxt;
  glyph_t                   out_glyph_r, out_glyph_nxt;
  logic                     out_last_nxt;

  // shared units
  logic [11:0]              rom_ang;
  logic [ROM_AW-1:0]        rom_addr;
  logic [E_W-1:0]           rom_q;
  logic signed [E_W-1:0]    sin_val;
  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [PW-1:0]     mul_p;
  logic                     div_start;
  logic [DV_W-1:0]          div_dividend;
  logic [DV_W-1:0]          div_quo;
  logic                     div_done;

  // march step
  logic signed [Q_W-1:0]    qx_step, qy_step;
  logic [D_W-1:0]           d_step;
  logic                     off_map;
  logic                     wall_bit;

  // corner vectors
  logic [4:0]               cxk, cyk;
  logic signed [V_W-1:0]    vx, vy;
  logic signed [PW-1:0]     cr_diff;

  // division set-up
  logic signed [D_W:0]      dm;
  logic signed [NUM_W-1:0]  num;
  logic [19:0]              d20;
  logic [CEIL_W-1:0]        quo_c;

  // row glyph
  logic signed [CEIL_W-1:0] ys, floor_row;
  logic [11:0]              m12;
  glyph_t                   floor_glyph, row_glyph;

  assign busy         = !(state_r == ST_IDLE);
  assign out_glyph    = out_glyph_r;

  gcr_sin_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q_r  (rom_q)
  );

  gcr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  gcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  ({d_r, 1'b0}),
    .quo_r    (div_quo),
    .done_r   (div_done)
  );

  // fold the angle into the quarter-wave table
  always_comb begin
    rom_ang  = (state_r == ST_SIN_X) ? ang_r : ang_r + 12'd1024;
    rom_addr = rom_ang[10] ? ROM_AW'(11'd1024 - {1'b0, rom_ang[9:0]})
                           : {1'b0, rom_ang[9:0]};
  end

  // sign of the value now leaving the ROM
  always_comb begin
    if (state_r == ST_SIN_Y) begin
      sin_val = ang_r[11] ? -signed'(rom_q) : signed'(rom_q);
    end else begin
      sin_val = (ang_r + 12'd1024) >= 12'd2048 ? -signed'(rom_q) : signed'(rom_q);
    end
  end

  // advance the ray by one step
  always_comb begin
    qx_step  = qx_r + stepx_r;
    qy_step  = qy_r + stepy_r;
    d_step   = d_r + STEP_D;
    off_map  = qx_step[Q_W-1] || qy_step[Q_W-1] ||
               (qx_step[Q_W-1:26] >= (Q_W - 26)'(MAP_SIZE)) ||
               (qy_step[Q_W-1:26] >= (Q_W - 26)'(MAP_SIZE));
    wall_bit = wall_r[qy_step[29:28]][{qy_step[27:26], qx_step[29:26]}];
  end

  // corner k of the hit cell relative to the viewer
  always_comb begin
    cxk     = 5'(cx_r) + 5'(k_r[1]);
    cyk     = 5'(cy_r) + 5'(k_r[0]);
    vx      = signed'({1'b0, cxk, 12'b0}) - signed'({2'b0, px_r});
    vy      = signed'({1'b0, cyk, 12'b0}) - signed'({2'b0, py_r});
    cr_diff = acc_r - mul_p;
  end

  // select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_DIST) begin
      case (ph_r)
        3'd0: begin
          mul_a = MW'(vx);
          mul_b = MW'(vx);
        end
        3'd1: begin
          mul_a = MW'(vy);
          mul_b = MW'(vy);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else if (state_r == ST_TEST) begin
      case (ph_r)
        3'd0: begin
          mul_a = MW'(ex_r);
          mul_b = MW'(vx);
        end
        3'd1: begin
          mul_a = MW'(ey_r);
          mul_b = MW'(vy);
        end
        3'd2: begin
          mul_a = MW'(ex_r);
          mul_b = MW'(vy);
        end
        3'd3: begin
          mul_a = MW'(ey_r);
          mul_b = MW'(vx);
        end
        3'd4: begin
          mul_a = MW'(cr_diff);
          mul_b = MW'(cr_diff);
        end
        3'd5: begin
          mul_a = MW'(EDGE_SIN2);
          mul_b = signed'({1'b0, dsq_r[k_r]});
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  // ceiling row numerator and shade inputs
  always_comb begin
    dm           = signed'({1'b0, d_r}) - (D_W + 1)'(8192);
    num          = NUM_W'(dm) * H_S;
    div_dividend = num[NUM_W-1] ? DV_W'(-num) : DV_W'(num);
    d20          = 20'(d_r);
    quo_c        = div_quo[CEIL_W-1:0];
  end

  // glyph for the current row
  always_comb begin
    ys        = signed'(CEIL_W'(y_r));
    floor_row = H_C - ceil_r;
    m12       = 12'(SCREEN_HEIGHT) - 12'(y_r);
    if (m12 * 12'd8 < 12'(SCREEN_HEIGHT)) begin
      floor_glyph = GLYPH_HASH;
    end else if (m12 * 12'd8 < 12'(3 * SCREEN_HEIGHT)) begin
      floor_glyph = GLYPH_X;
    end else if (m12 * 12'd20 < 12'(9 * SCREEN_HEIGHT)) begin
      floor_glyph = GLYPH_DOT;
    end else begin
      floor_glyph = GLYPH_BLANK;
    end
    if (ys < ceil_r) begin
      row_glyph = GLYPH_BLANK;
    end else if (ys > ceil_r && ys <= floor_row) begin
      row_glyph = shade_r;
    end else begin
      row_glyph = floor_glyph;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    ang_nxt       = ang_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    stepx_nxt     = stepx_r;
    stepy_nxt     = stepy_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    d_nxt         = d_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    k_nxt         = k_r;
    far_nxt       = far_r;
    ph_nxt        = ph_r;
    acc_nxt       = acc_r;
    dot_nxt       = dot_r;
    dsq_new       = DSQ_W'(acc_r + mul_p);
    dsq_we        = 1'b0;
    edge_nxt      = edge_r;
    shade_nxt     = shade_r;
    ceil_nxt      = ceil_r;
    y_nxt         = y_r;
    div_start     = 1'b0;
    out_valid_nxt = 1'b0;
    out_row_nxt   = out_row;
    out_glyph_nxt = out_glyph_r;
    out_last_nxt  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          px_nxt    = in_viewer_x;
          py_nxt    = in_viewer_y;
          ang_nxt   = in_view_angle - HALF_FOV + COL_TAB[in_column];
          state_nxt = ST_SIN_X;
        end
      end
      ST_SIN_X: begin
        state_nxt = ST_SIN_Y;
      end
      ST_SIN_Y: begin
        ex_nxt    = sin_val;
        state_nxt = ST_SIN_E;
      end
      ST_SIN_E: begin
        ey_nxt    = sin_val;
        state_nxt = ST_STEPC;
      end
      ST_STEPC: begin
        stepx_nxt = Q_W'(ex_r) * Q_W'(STEP_S);
        stepy_nxt = Q_W'(ey_r) * Q_W'(STEP_S);
        qx_nxt    = signed'({3'b0, px_r, 14'b0});
        qy_nxt    = signed'({3'b0, py_r, 14'b0});
        d_nxt     = '0;
        edge_nxt  = 1'b0;
        state_nxt = ST_MARCH;
      end
      ST_MARCH: begin
        if (d_r >= DEPTH_D) begin
          state_nxt = ST_DIVS;
        end else if (off_map) begin
          d_nxt     = DEPTH_D;
          state_nxt = ST_DIVS;
        end else begin
          d_nxt  = d_step;
          qx_nxt = qx_step;
          qy_nxt = qy_step;
          if (wall_bit) begin
            cx_nxt    = qx_step[29:26];
            cy_nxt    = qy_step[29:26];
            k_nxt     = '0;
            ph_nxt    = '0;
            far_nxt   = '0;
            state_nxt = ST_DIST;
          end
        end
      end
      ST_DIST: begin
        // squared distance of each corner, keep the farthest
        case (ph_r)
          3'd0: ph_nxt = 3'd1;
          3'd1: begin
            acc_nxt = mul_p;
            ph_nxt  = 3'd2;
          end
          default: begin
            dsq_we = 1'b1;
            if (k_r == 2'd0 || dsq_new >= dsq_r[far_r]) begin
              far_nxt = k_r;
            end
            ph_nxt = 3'd0;
            k_nxt  = k_r + 2'd1;
            if (k_r == 2'd3) begin
              state_nxt = ST_TEST;
            end
          end
        endcase
      end
      ST_TEST: begin
        // angular test against the three nearer corners
        case (ph_r)
          3'd0: begin
            if (k_r == far_r) begin
              k_nxt = k_r + 2'd1;
              if (k_r == 2'd3) state_nxt = ST_DIVS;
            end else begin
              ph_nxt = 3'd1;
            end
          end
          3'd1: begin
            acc_nxt = mul_p;
            ph_nxt  = 3'd2;
          end
          3'd2: begin
            dot_nxt = acc_r + mul_p;
            ph_nxt  = 3'd3;
          end
          3'd3: begin
            acc_nxt = mul_p;
            ph_nxt  = 3'd4;
          end
          3'd4: ph_nxt = 3'd5;
          3'd5: begin
            acc_nxt = mul_p;
            ph_nxt  = 3'd6;
          end
          default: begin
            if (dot_r > 0 && acc_r < mul_p) edge_nxt = 1'b1;
            ph_nxt = 3'd0;
            k_nxt  = k_r + 2'd1;
            if (k_r == 2'd3) state_nxt = ST_DIVS;
          end
        endcase
      end
      ST_DIVS: begin
        div_start = 1'b1;
        if (edge_r) begin
          shade_nxt = GLYPH_BLANK;
        end else if ({d20[17:0], 2'b0} <= 20'(DEPTH_Q12)) begin
          shade_nxt = GLYPH_FULL;
        end else if (d20 * 20'd3 < 20'(DEPTH_Q12)) begin
          shade_nxt = GLYPH_DARK;
        end else if ({d20[18:0], 1'b0} < 20'(DEPTH_Q12)) begin
          shade_nxt = GLYPH_MEDIUM;
        end else if (d_r < DEPTH_D) begin
          shade_nxt = GLYPH_LIGHT;
        end else begin
          shade_nxt = GLYPH_BLANK;
        end
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          ceil_nxt  = num[NUM_W-1] ? -signed'(quo_c) : signed'(quo_c);
          y_nxt     = '0;
          state_nxt = ST_ROWS;
        end
      end
      ST_ROWS: begin
        out_valid_nxt = 1'b1;
        out_row_nxt   = y_r;
        out_glyph_nxt = row_glyph;
        out_last_nxt  = (y_r == ROW_W'(SCREEN_HEIGHT - 1));
        y_nxt         = y_r + 1'b1;
        if (y_r == ROW_W'(SCREEN_HEIGHT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state and wall map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid    <= 1'b0;
      out_last_row <= 1'b0;
      for (int i = 0; i < 4; i++) wall_r[i] <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid    <= out_valid_nxt;
      out_last_row <= out_last_nxt;
      if (cfg_we && (cfg_index inside {[CFG_WALL_A:CFG_WALL_D]})) begin
        wall_r[cfg_index[1:0]] <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    ang_r       <= ang_nxt;
    ex_r        <= ex_nxt;
    ey_r        <= ey_nxt;
    stepx_r     <= stepx_nxt;
    stepy_r     <= stepy_nxt;
    qx_r        <= qx_nxt;
    qy_r        <= qy_nxt;
    d_r         <= d_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    k_r         <= k_nxt;
    far_r       <= far_nxt;
    ph_r        <= ph_nxt;
    acc_r       <= acc_nxt;
    dot_r       <= dot_nxt;
    edge_r      <= edge_nxt;
    shade_r     <= shade_nxt;
    ceil_r      <= ceil_nxt;
    y_r         <= y_nxt;
    out_row     <= out_row_nxt;
    out_glyph_r <= out_glyph_nxt;
    if (dsq_we) dsq_r[k_r] <= dsq_new;
  end

endmodule

`default_nettype wire

### hdl/gcr_sin_rom.sv
// ----------------------------------------------------------------------------
// gcr_sin_rom
// Quarter-wave sine ROM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_sin_rom
  import gcr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [ROM_AW-1:0] addr,
  output logic      [E_W-1:0]    q_r
);

  // register the table entry
  always_ff @(posedge clk) begin
    q_r <= SIN_TAB[addr];
  end

endmodule

`default_nettype wire

### hdl/gcr_mul.sv
// ----------------------------------------------------------------------------
// gcr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_mul
  import gcr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic signed [MW-1:0] a,
  input  wire logic signed [MW-1:0] b,
  output logic      signed [PW-1:0] p_r
);

  // hold the product for the sequencer
  always_ff @(posedge clk) begin
    p_r <= PW'(a) * PW'(b);
  end

endmodule

`default_nettype wire

### hdl/gcr_div.sv
// ----------------------------------------------------------------------------
// gcr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_div
  import gcr_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [DV_W-1:0] dividend,
  input  wire logic [DS_W-1:0] divisor,
  output logic      [DV_W-1:0] quo_r,
  output logic                 done_r
);

  localparam int CNT_W = $clog2(DV_W + 1);

  logic [DS_W:0]    rem_r, rem_nxt;
  logic [DS_W-1:0]  den_r, den_nxt;
  logic [DV_W-1:0]  quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_nxt;
  logic [DS_W:0]    rem_sh;

  // shift in one dividend bit, subtract where it fits
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[DS_W-1:0], quo_r[DV_W-1]};
    if (start) begin
      rem_nxt = '0;
      den_nxt = divisor;
      quo_nxt = dividend;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        quo_nxt = {quo_r[DV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[DV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DV_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

endmodule

`default_nettype wire

### hdl/gcr_checker.sv
// ----------------------------------------------------------------------------
// gcr_checker
// Port-level checks of the raycaster's row stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gcr_checker
  import gcr_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             out_valid,
  input wire logic [ROW_W-1:0] out_row,
  input wire logic             out_last_row
);

  // an accepted item makes the block busy and shows no row at once
  `GCR_ASSERT_NEXT(a_take_busy, start && !busy, busy && !out_valid)
  // the bottom row carries the last-row mark
  `GCR_ASSERT_NOW(a_last_row, out_valid && out_last_row, out_row == ROW_W'(SCREEN_HEIGHT - 1))
  // rows follow one another without gaps
  `GCR_ASSERT_NEXT(a_row_seq, out_valid && !out_last_row, out_valid && out_row == $past(out_row) + 1'b1)
  // the stream ends after the bottom row
  `GCR_ASSERT_NEXT(a_row_end, out_valid && out_last_row, !out_valid)

endmodule

bind grid_column_raycaster gcr_checker u_gcr_checker (.*);

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for grid_column_raycaster: casts directed and random
// columns over several wall maps and checks every emitted row glyph against
// a column predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import gcr_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PROBE_ROW      = 17;
  localparam int NO_TYPED       = -1;

  typedef struct {
    logic [5:0] row;
    logic [2:0] glyph;
    logic       last_row;
  } row_exp_t;

  typedef struct {
    logic [6:0]  column;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [11:0] angle;
    int          probe_glyph;   // typed glyph for PROBE_ROW, or NO_TYPED
  } column_vec_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [6:0]  in_column;
  logic [15:0] in_viewer_x;
  logic [15:0] in_viewer_y;
  logic [11:0] in_view_angle;
  logic        out_valid;
  logic [5:0]  out_row;
  logic [2:0]  out_glyph;
  logic        out_last_row;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  row_exp_t    glyph_q[$];
  logic [63:0] wall_map[4];
  int          mismatches;
  int          columns_cast;
  int          rows_seen;
  int          quiet_cycles;
  int          sender_idle_pct;

  grid_column_raycaster dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_column(in_column), .in_viewer_x(in_viewer_x),
    .in_viewer_y(in_viewer_y), .in_view_angle(in_view_angle),
    .out_valid(out_valid), .out_row(out_row), .out_glyph(out_glyph),
    .out_last_row(out_last_row),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH t=%0t %s", $time, what);
  endtask

  // Quarter-wave sine magnitude, Q1.14
  function automatic longint quarter_mag(input int k);
    longint unsigned x, x2, t, s, r;
    x  = (longint'(k) * 64'd3373259426) / 2048;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824 - x2 / 72;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    r  = (s + 64'd32768) >> 16;
    if (r > 64'd16384) r = 64'd16384;
    return longint'(r);
  endfunction

  function automatic longint sine14(input logic [11:0] a);
    longint v;
    v = a[10] ? quarter_mag(1024 - int'(a[9:0])) : quarter_mag(int'(a[9:0]));
    return a[11] ? -v : v;
  endfunction

  function automatic bit wall_at(input longint cy, input longint cx);
    logic [63:0] r;
    r = wall_map[cy[3:2]];
    return r[cy[1:0] * 16 + cx[3:0]];
  endfunction

  // Cast one column and queue its expected rows
  task automatic predict_column(input column_vec_t v);
    logic [11:0] ang;
    longint      ex, ey, px, py, d, qx, qy, cx, cy, dotp, cr, num, den, ceil_r, floor_r, m;
    longint      vxs[4], vys[4], dsq[4];
    longint      depth;
    bit          hit, edge_mark;
    int          far_k;
    logic [2:0]  shade, g;
    row_exp_t    e;
    depth = longint'(DEPTH_Q12);
    px  = longint'(v.vx);
    py  = longint'(v.vy);
    ang = 12'((int'(v.angle) + 4096 * 64 - FOV_UNITS / 2
               + (int'(v.column) * FOV_UNITS) / SCREEN_WIDTH) & 12'hFFF);
    ex  = sine14(ang);
    ey  = sine14(ang + 12'd1024);
    d = 0;
    hit = 0;
    edge_mark = 0;
    // march until a wall, the map border or full depth
    while (!hit && d < depth) begin
      d  = d + STEP_Q12;
      qx = px * 16384 + ex * d;
      qy = py * 16384 + ey * d;
      if (qx < 0 || qy < 0 || (qx >>> 26) >= MAP_SIZE || (qy >>> 26) >= MAP_SIZE) begin
        hit = 1;
        d = depth;
      end else begin
        cx = qx >>> 26;
        cy = qy >>> 26;
        if (wall_at(cy, cx)) begin
          hit = 1;
          far_k = 0;
          for (int k = 0; k < 4; k++) begin
            vxs[k] = (cx + (k >> 1)) * 4096 - px;
            vys[k] = (cy + (k & 1)) * 4096 - py;
            dsq[k] = vxs[k] * vxs[k] + vys[k] * vys[k];
            if (dsq[k] >= dsq[far_k]) far_k = k;
          end
          // skip the farthest corner, test the other three
          for (int k = 0; k < 4; k++) begin
            if (k != far_k) begin
              dotp = ex * vxs[k] + ey * vys[k];
              cr   = ex * vys[k] - ey * vxs[k];
              if (dotp > 0 && cr * cr < longint'(EDGE_SIN2) * dsq[k]) edge_mark = 1;
            end
          end
        end
      end
    end
    num = SCREEN_HEIGHT * (d - 8192);
    den = 2 * d;
    ceil_r  = (num >= 0) ? num / den : -((-num) / den);
    floor_r = SCREEN_HEIGHT - ceil_r;
    if (d * 4 <= depth)      shade = GLYPH_FULL;
    else if (d * 3 < depth)  shade = GLYPH_DARK;
    else if (d * 2 < depth)  shade = GLYPH_MEDIUM;
    else if (d < depth)      shade = GLYPH_LIGHT;
    else                     shade = GLYPH_BLANK;
    if (edge_mark) shade = GLYPH_BLANK;
    for (int y = 0; y < SCREEN_HEIGHT; y++) begin
      if (y < ceil_r) begin
        g = GLYPH_BLANK;
      end else if (y > ceil_r && y <= floor_r) begin
        g = shade;
      end else begin
        m = SCREEN_HEIGHT - y;
        if (8 * m < SCREEN_HEIGHT)           g = GLYPH_HASH;
        else if (8 * m < 3 * SCREEN_HEIGHT)  g = GLYPH_X;
        else if (20 * m < 9 * SCREEN_HEIGHT) g = GLYPH_DOT;
        else                                 g = GLYPH_BLANK;
      end
      if (y == PROBE_ROW && v.probe_glyph != NO_TYPED) g = 3'(v.probe_glyph);
      e.row      = 6'(y);
      e.glyph    = g;
      e.last_row = (y == SCREEN_HEIGHT - 1);
      glyph_q    = {glyph_q, e};
    end
  endtask

  // Present one column, wait until busy falls again, then queue its rows
  task automatic cast_column(input column_vec_t v);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start         <= 1'b1;
    in_column     <= v.column;
    in_viewer_x   <= v.vx;
    in_viewer_y   <= v.vy;
    in_view_angle <= v.angle;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_column(v);
    columns_cast++;
  endtask

  // Drain the block, then write all four map registers (and a stray index)
  task automatic load_map(input logic [63:0] a, b, c, dd);
    logic [63:0] vals[4];
    vals = '{a, b, c, dd};
    @(negedge clk);
    start <= 1'b0;
    while (glyph_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= (i < 4) ? 3'(i) : CFG_WALL_D + 3'd1 + 3'($urandom_range(3));
      cfg_wdata <= (i < 4) ? vals[i] : {$urandom, $urandom};
      if (i < 4) wall_map[i] = vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_walls(input int density);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (density < 2) r = r & {$urandom, $urandom};
    if (density < 1) r = r & {$urandom, $urandom};
    return r;
  endfunction

  // Check each emitted row against the oldest expectation; watch for stalls
  always @(posedge clk) begin
    row_exp_t e;
    if (rst_n) begin
      if (out_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
      if (out_valid) begin
        rows_seen++;
        if (glyph_q.size() == 0) begin
          report_mismatch($sformatf("unexpected row %0d", out_row));
        end else begin
          e = glyph_q.pop_front();
          if (out_row !== e.row)
            report_mismatch($sformatf("row %0d, want %0d", out_row, e.row));
          if (out_glyph !== e.glyph)
            report_mismatch($sformatf("row %0d glyph %0d, want %0d",
                                      e.row, out_glyph, e.glyph));
          if (out_last_row !== e.last_row)
            report_mismatch($sformatf("row %0d last_row %0b", e.row, out_last_row));
        end
      end
    end
  end

  initial begin
    column_vec_t directed[$];
    column_vec_t v;
    int          pct_list[4];
    int          wait_cycles;
    pct_list      = '{0, 47, 0, 29};
    mismatches    = 0;
    columns_cast  = 0;
    rows_seen     = 0;
    quiet_cycles  = 0;
    sender_idle_pct = 0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_column     = '0;
    in_viewer_x   = '0;
    in_viewer_y   = '0;
    in_view_angle = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    for (int i = 0; i < 4; i++) wall_map[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty map after reset: every ray leaves the map, wall rows are blank
    directed = '{
      '{7'd0,   16'd0,     16'd0,     12'd0,    int'(GLYPH_BLANK)},
      '{7'd119, 16'hFFFF,  16'hFFFF,  12'hFFF,  int'(GLYPH_BLANK)},
      '{7'd127, 16'h8000,  16'h8000,  12'd2048, int'(GLYPH_BLANK)},
      '{7'd60,  16'h0001,  16'h0001,  12'd2048, int'(GLYPH_BLANK)}
    };
    foreach (directed[i]) cast_column(directed[i]);

    // single wall at map cell x=8, y=9
    load_map(64'd0, 64'd0, 64'd1 << 24, 64'd0);
    directed = '{
      '{7'd60,  16'h8800,  16'h8800,  12'd0,    int'(GLYPH_FULL)},   // straight on
      '{7'd60,  16'h8000,  16'h8800,  12'd0,    int'(GLYPH_BLANK)},  // along an edge
      '{7'd60,  16'h8000,  16'h9000,  12'd0,    NO_TYPED},           // viewer on a corner
      '{7'd60,  16'h8800,  16'h0000,  12'd0,    NO_TYPED},           // far hit
      '{7'd0,   16'h8800,  16'h8800,  12'd0,    NO_TYPED},
      '{7'd119, 16'h8800,  16'h8800,  12'd0,    NO_TYPED},
      '{7'd120, 16'h8800,  16'h8800,  12'd0,    NO_TYPED},           // past the view edge
      '{7'd127, 16'h8800,  16'h8800,  12'hFFF,  NO_TYPED},
      '{7'd60,  16'h9800,  16'h9800,  12'd2560, NO_TYPED},
      '{7'd60,  16'h0800,  16'h0800,  12'd2048, int'(GLYPH_BLANK)}   // leaves the map
    };
    foreach (directed[i]) cast_column(directed[i]);

    // every cell a wall: viewer always starts inside one
    load_map('1, '1, '1, '1);
    directed = '{
      '{7'd0,   16'h0000,  16'h0000,  12'd0,    NO_TYPED},
      '{7'd60,  16'h4321,  16'h1234,  12'd1024, NO_TYPED},
      '{7'd119, 16'hFFFF,  16'hFFFF,  12'd3072, NO_TYPED}
    };
    foreach (directed[i]) cast_column(directed[i]);

    // random phases, each with its own map; sender pacing is set per phase
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = pct_list[ph];
      load_map(rand_walls(ph % 3), rand_walls(ph % 3), rand_walls(ph % 3),
               rand_walls(ph % 3));
      for (int n = 0; n < 105; n++) begin
        v.column      = ($urandom_range(19) == 0) ? 7'($urandom_range(127))
                                                  : 7'($urandom_range(119));
        v.vx          = 16'($urandom);
        v.vy          = 16'($urandom);
        v.angle       = 12'($urandom);
        v.probe_glyph = NO_TYPED;
        cast_column(v);
      end
    end

    // drain, then let the block settle
    @(negedge clk);
    start <= 1'b0;
    wait_cycles = 0;
    while (glyph_q.size() != 0 && wait_cycles < 20 * WATCHDOG_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (300) @(posedge clk);
    if (glyph_q.size() != 0)
      report_mismatch($sformatf("%0d rows never emitted", glyph_q.size()));
    $display("Cast %0d columns over 7 wall maps, checked %0d glyph rows.",
             columns_cast, rows_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/gcr_pkg.sv
hdl/gcr_sin_rom.sv
hdl/gcr_mul.sv
hdl/gcr_div.sv
hdl/grid_column_raycaster.sv
hdl/gcr_checker.sv
dv/tb.sv
